### src/pge_pkg.sv
`default_nettype none

package pge_pkg;

	localparam int KNOB_W     = 14;
	localparam int AMT_W      = 16;
	localparam int AMT_FRAC   = 15;
	localparam int RANGE_W    = 2;
	localparam int TICK_W     = 20;
	localparam int CH_W       = 4;
	localparam int CV_W       = 15;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam int LEN_W      = 35;
	localparam int END_W      = 20;
	localparam int PROD_W     = CV_W + AMT_W;
	localparam int KNOB_NS_W  = 34;
	localparam int SCL_W      = PROD_W + 20;
	localparam int Q_W        = SCL_W - AMT_FRAC;
	localparam int SUM_W      = LEN_W + 2;
	localparam int DIV_STEPS  = 2;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

	localparam int NS_PER_MS  = 1000000;
	localparam int CV_LIMIT   = 10000;
	localparam int TICK_RESET = 20833;

	localparam int S_TDATA_W = 24;
	localparam int S_TUSER_W = 5;
	localparam int M_TDATA_W = 8;
	localparam int M_TUSER_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_KNOB     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AMOUNT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_SHOT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TICK     = 3'd4;

	localparam logic [RANGE_W-1:0] RANGE_LONG   = 2'd0;
	localparam logic [RANGE_W-1:0] RANGE_MEDIUM = 2'd1;
	localparam logic [RANGE_W-1:0] RANGE_SHORT  = 2'd2;

	typedef struct packed {
		logic [KNOB_W-1:0]        knob_length_ms;
		logic signed [AMT_W-1:0]  cv_amount;
		logic [RANGE_W-1:0]       range_select;
		logic                     one_shot_mode;
		logic [TICK_W-1:0]        tick_ns;
	} cfg_t;

	typedef struct packed {
		logic cap;
		logic mul;
		logic scale;
		logic sum;
		logic div_step;
		logic upd;
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic out_free;
	} sts_t;

	function automatic logic [LEN_W-1:0] cd_rem(input logic [LEN_W-1:0] r,
			input logic [TICK_W-1:0] t);
		logic [LEN_W-1:0] tl;
		tl = LEN_W'(t);
		return (r > tl) ? (r - tl) : '0;
	endfunction

	function automatic logic [END_W-1:0] cd_end(input logic [END_W-1:0] r,
			input logic [TICK_W-1:0] t);
		logic [END_W-1:0] tl;
		tl = END_W'(t);
		return (r > tl) ? (r - tl) : '0;
	endfunction

endpackage

`default_nettype wire

### src/poly_gate_pulse_extender.sv
`default_nettype none

// Sixteen-channel retriggerable pulse extender. Each request is one sample tick for one
// channel and returns exactly one result carrying the pulse and end-trigger levels. A
// request is taken only when the block is idle, so a new one waits until the last is through:
// acceptance, two multiplier stages, one add-and-limit stage and one state update, at
// whose end the result is loaded into the output register. The short range adds the
// divide by ten, which first forms the partial products and then sums them.
// A result left waiting in the output register stalls the state update of the request
// behind it, and with it the input. Configuration writes take effect at once and must
// only be issued while no request is in flight.

module poly_gate_pulse_extender
	import pge_pkg::*;
#(
	parameter int CHANNELS = 16
)
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,  // gate_level, reset_level, length_cv_mv[14:0]
	input  logic [S_TUSER_W-1:0]  s_tuser,  // channel[3:0], channel_active
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,  // pulse_out, end_out
	output logic [M_TUSER_W-1:0]  m_tuser,  // out_channel[3:0]
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t              cfg_q;
	cmd_t              cmd;
	sts_t              sts;
	logic              need_div;
	logic              out_free;
	logic [LEN_W-1:0]  len;
	logic              out_pulse;
	logic              out_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.knob_length_ms <= '0;
			cfg_q.cv_amount      <= '0;
			cfg_q.range_select   <= RANGE_MEDIUM;
			cfg_q.one_shot_mode  <= 1'b0;
			cfg_q.tick_ns        <= TICK_W'(TICK_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KNOB:     cfg_q.knob_length_ms <= cfg_wdata[KNOB_W-1:0];
				REG_AMOUNT:   cfg_q.cv_amount      <= $signed(cfg_wdata[AMT_W-1:0]);
				REG_RANGE:    cfg_q.range_select   <= cfg_wdata[RANGE_W-1:0];
				REG_ONE_SHOT: cfg_q.one_shot_mode  <= cfg_wdata[0];
				REG_TICK:     cfg_q.tick_ns        <= cfg_wdata[TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign sts.need_div = need_div;
	assign sts.out_free = out_free;

	pge_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pge_len u_len (
		.clk      (clk),
		.cmd      (cmd),
		.cfg      (cfg_q),
		.cv_in    ($signed(s_tdata[2 +: CV_W])),
		.need_div (need_div),
		.len      (len)
	);

	pge_chan #(
		.CHANNELS (CHANNELS)
	) u_chan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg       (cfg_q),
		.ch_in     (s_tuser[CH_W-1:0]),
		.act_in    (s_tuser[CH_W]),
		.gate_in   (s_tdata[0]),
		.rst_in    (s_tdata[1]),
		.len       (len),
		.m_ready   (m_tready),
		.out_free  (out_free),
		.m_valid   (m_tvalid),
		.out_ch    (m_tuser),
		.out_pulse (out_pulse),
		.out_end   (out_end)
	);

	assign m_tdata = {{(M_TDATA_W - 2){1'b0}}, out_end, out_pulse};

endmodule

`default_nettype wire

### src/pge_ctrl.sv
`default_nettype none

module pge_ctrl
	import pge_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SCALE,
		ST_SUM,
		ST_DIV,
		ST_UPD
	} state_t;

	state_t                 state_q;
	logic [DIV_CNT_W-1:0]   div_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					div_cnt_q <= '0;
					state_q   <= sts.need_div ? ST_DIV : ST_UPD;
				end
				ST_DIV: begin
					if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) state_q <= ST_UPD;
					div_cnt_q <= div_cnt_q + 1'b1;
				end
				ST_UPD: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.cap      = s_tvalid && (state_q == ST_IDLE);
		cmd.mul      = (state_q == ST_MUL);
		cmd.scale    = (state_q == ST_SCALE);
		cmd.sum      = (state_q == ST_SUM);
		cmd.div_step = (state_q == ST_DIV);
		cmd.upd      = (state_q == ST_UPD) && sts.out_free;
	end

`ifndef SYNTHESIS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while another is in flight");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_cnt_q < DIV_CNT_W'(DIV_STEPS)))
		else $error("divider ran past its last step");
`endif

endmodule

`default_nettype wire

### src/pge_len.sv
`default_nettype none

module pge_len
	import pge_pkg::*;
(
	input  logic                   clk,
	input  cmd_t                   cmd,
	input  cfg_t                   cfg,
	input  logic signed [CV_W-1:0] cv_in,
	output logic                   need_div,
	output logic [LEN_W-1:0]       len
);

	localparam logic signed [CV_W-1:0]  CV_HI    = CV_W'(CV_LIMIT);
	localparam logic signed [CV_W-1:0]  CV_LO    = CV_W'(-CV_LIMIT);
	localparam logic signed [SUM_W-1:0] MIN_SUM  = SUM_W'(NS_PER_MS);
	localparam int                      RECIP_SH = 38;
	localparam logic [LEN_W-1:0]        RECIP    =
		LEN_W'(((64'd1 << RECIP_SH) + 64'd9) / 64'd10);
	localparam int                      LO_W     = 18;
	localparam int                      PL_W     = LO_W + LEN_W;
	localparam int                      PH_W     = LEN_W - LO_W + LEN_W;
	localparam int                      ACC_W    = PH_W + 1;
	localparam int                      ACC_SH   = RECIP_SH - LO_W;

	logic signed [CV_W-1:0]   cv_q;
	logic signed [CV_W-1:0]   cvc;
	logic signed [PROD_W-1:0] prod_s1;
	logic [KNOB_NS_W-1:0]     knob_s1;
	logic signed [SCL_W-1:0]  scl_s2;
	logic [KNOB_NS_W-1:0]     knob_s2;
	logic signed [SCL_W-1:0]  scl_adj;
	logic signed [Q_W-1:0]    q;
	logic signed [SUM_W-1:0]  ns_sum;
	logic [LEN_W-1:0]         ns_min;
	logic [LEN_W-1:0]         ns_q;
	logic [PL_W-1:0]          pl_q;
	logic [PH_W-1:0]          ph_q;
	logic [ACC_W-1:0]         acc;
	logic [LEN_W-1:0]         quo_q;
	logic [LEN_W:0]           dbl;

	always_comb begin
		if (cv_q > CV_HI) cvc = CV_HI;
		else if (cv_q < CV_LO) cvc = CV_LO;
		else cvc = cv_q;
	end

	// round toward zero before dropping the fraction
	assign scl_adj = scl_s2[SCL_W-1] ? (scl_s2 + SCL_W'((1 << AMT_FRAC) - 1)) : scl_s2;
	assign q       = $signed(scl_adj[SCL_W-1:AMT_FRAC]);
	assign ns_sum  = $signed({{(SUM_W - KNOB_NS_W){1'b0}}, knob_s2}) + SUM_W'(q);
	assign ns_min  = (ns_sum < MIN_SUM) ? LEN_W'(NS_PER_MS) : ns_sum[LEN_W-1:0];

	// divide by ten: multiply by the rounded-up reciprocal, split in two partial products
	assign acc = {1'b0, ph_q} + ACC_W'(pl_q[PL_W-1:LO_W]);

	always_ff @(posedge clk) begin
		if (cmd.cap) cv_q <= cv_in;
		if (cmd.mul) begin
			prod_s1 <= cvc * cfg.cv_amount;
			knob_s1 <= KNOB_NS_W'(cfg.knob_length_ms) * KNOB_NS_W'(NS_PER_MS);
		end
		if (cmd.scale) begin
			scl_s2  <= prod_s1 * SCL_W'(NS_PER_MS);
			knob_s2 <= knob_s1;
		end
		if (cmd.sum) ns_q <= ns_min;
		if (cmd.div_step) begin
			pl_q  <= PL_W'(ns_q[LO_W-1:0]) * PL_W'(RECIP);
			ph_q  <= PH_W'(ns_q[LEN_W-1:LO_W]) * PH_W'(RECIP);
			quo_q <= LEN_W'(acc[ACC_W-1:ACC_SH]);
		end
	end

	assign need_div = (cfg.range_select == RANGE_SHORT);
	assign dbl      = {ns_q, 1'b0};
	assign len      = (cfg.range_select == RANGE_LONG) ?
		(dbl[LEN_W] ? '1 : dbl[LEN_W-1:0]) :
		((cfg.range_select == RANGE_SHORT) ? quo_q : ns_q);

endmodule

`default_nettype wire

### src/pge_chan.sv
`default_nettype none

module pge_chan
	import pge_pkg::*;
#(
	parameter int CHANNELS = 16
)
(
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  cfg_t             cfg,
	input  logic [CH_W-1:0]  ch_in,
	input  logic             act_in,
	input  logic             gate_in,
	input  logic             rst_in,
	input  logic [LEN_W-1:0] len,
	input  logic             m_ready,
	output logic             out_free,
	output logic             m_valid,
	output logic [CH_W-1:0]  out_ch,
	output logic             out_pulse,
	output logic             out_end
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic                prev_gate_q [CHANNELS];
	logic                blocked_q   [CHANNELS];
	logic [LEN_W-1:0]    rem_q       [CHANNELS];
	logic                prev_pulse_q[CHANNELS];
	logic [END_W-1:0]    end_rem_q   [CHANNELS];

	logic [CH_W-1:0]     ch_q;
	logic                act_q;
	logic                gate_q;
	logic                rst_q;

	logic                out_valid_q;
	logic [CH_W-1:0]     out_ch_q;
	logic                out_pulse_q;
	logic                out_end_q;

	logic                in_rng;
	logic [IDX_W-1:0]    idx;
	logic                pg;
	logic                blk;
	logic [LEN_W-1:0]    rem;
	logic                pp;
	logic [END_W-1:0]    er;
	logic                rise;
	logic                blk_n;
	logic [LEN_W-1:0]    rem_1;
	logic [LEN_W-1:0]    rem_n;
	logic                run;
	logic [END_W-1:0]    er_n;
	logic                fire;

	assign in_rng = ({1'b0, ch_q} < (CH_W + 1)'(CHANNELS));
	assign idx    = ch_q[IDX_W-1:0];

	always_comb begin
		pg   = prev_gate_q[idx];
		blk  = blocked_q[idx];
		rem  = rem_q[idx];
		pp   = prev_pulse_q[idx];
		er   = end_rem_q[idx];
		rise = gate_q && !pg;

		if (rst_q) begin
			blk_n = 1'b1;
			rem_1 = rem;
			rem_n = '0;
		end else begin
			blk_n = rise ? 1'b0 : blk;
			rem_1 = (rise && cfg.one_shot_mode) ? len : rem;
			if (blk_n) rem_n = rem_1;
			else if (gate_q && !cfg.one_shot_mode) rem_n = len;
			else rem_n = cd_rem(rem_1, cfg.tick_ns);
		end

		run = (rem_n != '0);

		if (pp && !run) begin
			er_n = (er < END_W'(NS_PER_MS)) ? END_W'(NS_PER_MS) : er;
			fire = 1'b1;
		end else if (er != '0) begin
			er_n = cd_end(er, cfg.tick_ns);
			fire = 1'b1;
		end else begin
			er_n = er;
			fire = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			ch_q   <= ch_in;
			act_q  <= act_in;
			gate_q <= gate_in;
			rst_q  <= rst_in;
		end
		if (cmd.upd) begin
			out_ch_q    <= ch_q;
			out_pulse_q <= in_rng && act_q && run;
			out_end_q   <= in_rng && act_q && fire;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				prev_gate_q[i]  <= 1'b0;
				blocked_q[i]    <= 1'b0;
				rem_q[i]        <= '0;
				prev_pulse_q[i] <= 1'b0;
				end_rem_q[i]    <= '0;
			end
		end else if (cmd.upd && in_rng) begin
			if (act_q) begin
				prev_gate_q[idx]  <= gate_q;
				blocked_q[idx]    <= blk_n;
				rem_q[idx]        <= rem_n;
				prev_pulse_q[idx] <= run;
				end_rem_q[idx]    <= er_n;
			end else begin
				prev_gate_q[idx]  <= 1'b0;
				blocked_q[idx]    <= 1'b0;
				prev_pulse_q[idx] <= 1'b0;
				end_rem_q[idx]    <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.upd) begin
			out_valid_q <= 1'b1;
		end else if (m_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_free  = !out_valid_q || m_ready;
	assign m_valid   = out_valid_q;
	assign out_ch    = out_ch_q;
	assign out_pulse = out_pulse_q;
	assign out_end   = out_end_q;

`ifndef SYNTHESIS
	a_quiet_out_of_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && ({1'b0, out_ch_q} >= (CH_W + 1)'(CHANNELS)))
			|-> (!out_pulse_q && !out_end_q))
		else $error("output driven for a channel beyond the channel count");

	a_reset_kills_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.upd && in_rng && act_q && rst_q) |=> !out_pulse_q)
		else $error("pulse high on a tick with reset asserted");
`endif

endmodule

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import pge_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASES = 8;
	localparam int PHASE_TICKS = 180;
	localparam int SQUEEZE_CYCLES = 400;
	localparam longint LEN_MAX = (64'd1 << LEN_W) - 1;

	typedef struct packed {
		logic [CH_W-1:0]        ch;
		logic                   active;
		logic                   gate;
		logic                   rst;
		logic signed [CV_W-1:0] cv;
	} tick_t;

	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic            pulse;
		logic            trig;
	} level_t;

	typedef enum logic [1:0] {ROW_TICK, ROW_KNOWN, ROW_WRITE} row_kind_e;

	typedef struct packed {
		row_kind_e              kind;
		tick_t                  t;
		level_t                 want;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_DATA_W-1:0]  val;
	} row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic [S_TUSER_W-1:0]  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [M_TUSER_W-1:0]  m_tuser;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// predictor copy of the registers and per-channel state
	logic [KNOB_W-1:0]        knob_ms;
	logic signed [AMT_W-1:0]  amount;
	logic [RANGE_W-1:0]       range_sel;
	logic                     one_shot;
	logic [TICK_W-1:0]        tick_len;

	bit               gate_was [16];
	bit               held_off [16];
	logic [LEN_W-1:0] pulse_left [16];
	bit               pulse_was [16];
	logic [END_W-1:0] trig_left [16];

	level_t awaited_levels [$];
	row_t   script [$];
	bit     gate_held [16];
	int     mismatches = 0;
	int     cycle_count = 0;
	int     squeeze_asked = 0;
	bit     steady = 1'b0;
	bit     focus = 1'b0;

	poly_gate_pulse_extender DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic longint run_down(input longint r);
		return (r > longint'(tick_len)) ? r - longint'(tick_len) : 0;
	endfunction

	function automatic logic [LEN_W-1:0] pulse_span(input logic signed [CV_W-1:0] cv_in);
		longint cv;
		longint ns;
		cv = cv_in;
		if (cv > CV_LIMIT)
			cv = CV_LIMIT;
		if (cv < -CV_LIMIT)
			cv = -CV_LIMIT;
		ns = longint'(knob_ms) * NS_PER_MS + (cv * longint'(amount) * NS_PER_MS) / 32768;
		if (ns < NS_PER_MS)
			ns = NS_PER_MS;
		case (range_sel)
			RANGE_LONG: ns = ns * 2;
			RANGE_SHORT: ns = ns / 10;
			default: ;
		endcase
		if (ns > LEN_MAX)
			ns = LEN_MAX;
		return ns[LEN_W-1:0];
	endfunction

	function automatic level_t advance_channel(input tick_t t);
		level_t r;
		bit rise;
		bit now_on;
		logic [LEN_W-1:0] span;
		r.ch = t.ch;
		r.pulse = 1'b0;
		r.trig = 1'b0;
		if (!t.active) begin
			gate_was[t.ch] = 0;
			pulse_was[t.ch] = 0;
			held_off[t.ch] = 0;
			trig_left[t.ch] = '0;
			return r;
		end
		rise = t.gate && !gate_was[t.ch];
		gate_was[t.ch] = t.gate;
		span = pulse_span(t.cv);
		if (t.rst) begin
			pulse_left[t.ch] = '0;
			held_off[t.ch] = 1;
		end else begin
			if (rise) begin
				held_off[t.ch] = 0;
				if (one_shot)
					pulse_left[t.ch] = span;
			end
			if (!held_off[t.ch]) begin
				if (t.gate && !one_shot)
					pulse_left[t.ch] = span;
				else
					pulse_left[t.ch] = LEN_W'(run_down(longint'(pulse_left[t.ch])));
			end
		end
		now_on = pulse_left[t.ch] != '0;
		if (pulse_was[t.ch] && !now_on) begin
			if (trig_left[t.ch] < END_W'(NS_PER_MS))
				trig_left[t.ch] = END_W'(NS_PER_MS);
			r.trig = 1'b1;
		end else if (trig_left[t.ch] != '0) begin
			trig_left[t.ch] = END_W'(run_down(longint'(trig_left[t.ch])));
			r.trig = 1'b1;
		end
		pulse_was[t.ch] = now_on;
		r.pulse = now_on;
		return r;
	endfunction

	function automatic int idle_span();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic tick_t random_tick();
		tick_t t;
		int r;
		t.ch = focus ? CH_W'($urandom_range(0, 3)) : CH_W'($urandom_range(0, 15));
		t.active = $urandom_range(0, 31) != 0;
		if ($urandom_range(0, 3) == 0)
			gate_held[t.ch] = !gate_held[t.ch];
		t.gate = gate_held[t.ch];
		t.rst = $urandom_range(0, 19) == 0;
		r = $urandom_range(0, 9);
		if (r < 6)
			t.cv = CV_W'(int'($urandom_range(0, 20000)) - 10000);
		else if (r < 8)
			t.cv = CV_W'($urandom);
		else
			case ($urandom_range(0, 5))
				0: t.cv = CV_W'(-16384);
				1: t.cv = CV_W'(16383);
				2: t.cv = CV_W'(-12000);
				3: t.cv = CV_W'(12000);
				4: t.cv = CV_W'(-10000);
				default: t.cv = CV_W'(10000);
			endcase
		return t;
	endfunction

	function automatic row_t tick_row(input row_kind_e kind, input int ch, input bit act,
			input bit g, input bit rs, input int cv, input bit p = 0, input bit f = 0);
		row_t row;
		row = '0;
		row.kind = kind;
		row.t.ch = CH_W'(ch);
		row.t.active = act;
		row.t.gate = g;
		row.t.rst = rs;
		row.t.cv = CV_W'(cv);
		row.want.ch = CH_W'(ch);
		row.want.pulse = p;
		row.want.trig = f;
		return row;
	endfunction

	function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		row_t row;
		row = '0;
		row.kind = ROW_WRITE;
		row.idx = idx;
		row.val = val;
		return row;
	endfunction

	task automatic send_tick(input tick_t t, input bit known, input level_t want);
		int gap;
		level_t next;
		gap = idle_span();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= S_TDATA_W'({t.cv, t.rst, t.gate});
		s_tuser <= {t.active, t.ch};
		do @(posedge clk); while (!s_tready);
		next = advance_channel(t);
		awaited_levels.push_back(known ? want : next);
	endtask

	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (awaited_levels.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_KNOB: knob_ms = val[KNOB_W-1:0];
			REG_AMOUNT: amount = val[AMT_W-1:0];
			REG_RANGE: range_sel = val[RANGE_W-1:0];
			REG_ONE_SHOT: one_shot = val[0];
			REG_TICK: tick_len = val[TICK_W-1:0];
			default: ;
		endcase
	endtask

	// receiver: random stalls, plus a long hold-off whenever one is asked for
	initial begin
		int hold;
		int squeeze_done;
		squeeze_done = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (squeeze_done != squeeze_asked) begin
				squeeze_done++;
				hold = SQUEEZE_CYCLES;
			end else begin
				hold = idle_span();
			end
			if (hold > 0) begin
				m_tready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(0, 15)) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		level_t seen;
		level_t want;
		if (arst_n && m_tvalid && m_tready) begin
			seen.ch = m_tuser[CH_W-1:0];
			seen.pulse = m_tdata[0];
			seen.trig = m_tdata[1];
			if (awaited_levels.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: ch %0d pulse %b trig %b",
						seen.ch, seen.pulse, seen.trig);
				mismatches++;
			end else begin
				want = awaited_levels.pop_front();
				if (seen.ch !== want.ch || seen.pulse !== want.pulse
						|| seen.trig !== want.trig) begin
					if (mismatches < 10)
						$display("mismatch: expected ch %0d pulse %b trig %b, got ch %0d pulse %b trig %b",
							want.ch, want.pulse, want.trig, seen.ch, seen.pulse, seen.trig);
					mismatches++;
				end
			end
		end
	end

	initial begin
		row_t row;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		knob_ms = '0;
		amount = '0;
		range_sel = RANGE_MEDIUM;
		one_shot = 1'b0;
		tick_len = TICK_W'(TICK_RESET);
		foreach (gate_was[i]) begin
			gate_was[i] = 0;
			held_off[i] = 0;
			pulse_left[i] = '0;
			pulse_was[i] = 0;
			trig_left[i] = '0;
			gate_held[i] = 0;
		end

		// reset defaults: 1 ms pulses, retrigger
		script.push_back(tick_row(ROW_KNOWN, 0, 1, 0, 0, 0, 0, 0));
		script.push_back(tick_row(ROW_KNOWN, 15, 0, 1, 1, -16384, 0, 0));
		script.push_back(tick_row(ROW_KNOWN, 0, 1, 1, 0, 16383, 1, 0));
		script.push_back(tick_row(ROW_KNOWN, 0, 1, 1, 1, 0, 0, 1));
		script.push_back(tick_row(ROW_TICK, 0, 1, 1, 0, 0));
		script.push_back(tick_row(ROW_TICK, 0, 1, 0, 0, 0));
		script.push_back(tick_row(ROW_TICK, 0, 1, 1, 0, -12000));
		script.push_back(tick_row(ROW_KNOWN, 0, 0, 1, 0, 0, 0, 0));
		script.push_back(tick_row(ROW_TICK, 0, 1, 0, 0, 0));
		// saturate the length
		script.push_back(cfg_row(REG_KNOB, 16383));
		script.push_back(cfg_row(REG_AMOUNT, 32767));
		script.push_back(cfg_row(REG_RANGE, CFG_DATA_W'(RANGE_LONG)));
		script.push_back(tick_row(ROW_TICK, 1, 1, 1, 0, 12000));
		script.push_back(tick_row(ROW_TICK, 1, 1, 0, 0, -16384));
		// negative sum falls back to the minimum
		script.push_back(cfg_row(REG_AMOUNT, CFG_DATA_W'(-32768)));
		script.push_back(cfg_row(REG_KNOB, 0));
		script.push_back(tick_row(ROW_TICK, 2, 1, 1, 0, 10000));
		// one-shot, short range, frozen timers
		script.push_back(cfg_row(REG_ONE_SHOT, 1));
		script.push_back(cfg_row(REG_RANGE, CFG_DATA_W'(RANGE_SHORT)));
		script.push_back(cfg_row(REG_TICK, 0));
		script.push_back(tick_row(ROW_TICK, 3, 1, 1, 0, 5000));
		script.push_back(tick_row(ROW_TICK, 3, 1, 1, 0, 0));
		script.push_back(tick_row(ROW_TICK, 3, 1, 0, 0, 0));
		// longest tick, range code three
		script.push_back(cfg_row(REG_TICK, 1048575));
		script.push_back(cfg_row(REG_RANGE, 3));
		script.push_back(tick_row(ROW_KNOWN, 4, 1, 1, 1, 0, 0, 0));
		script.push_back(tick_row(ROW_TICK, 4, 1, 1, 0, 0));
		script.push_back(tick_row(ROW_TICK, 4, 1, 0, 0, 0));
		script.push_back(tick_row(ROW_TICK, 4, 1, 1, 0, -1));
		script.push_back(tick_row(ROW_TICK, 3, 1, 0, 0, 0));
		script.push_back(tick_row(ROW_TICK, 3, 1, 0, 0, 0));
		script.push_back(cfg_row(REG_TICK, 1));
		script.push_back(tick_row(ROW_TICK, 5, 1, 1, 0, 7));

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			row = script[i];
			if (row.kind == ROW_WRITE) begin
				settle();
				write_reg(row.idx, row.val);
			end else begin
				send_tick(row.t, row.kind == ROW_KNOWN, row.want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
				0: begin
					write_reg(REG_KNOB, 0);
					write_reg(REG_AMOUNT, 32767);
					write_reg(REG_RANGE, CFG_DATA_W'(RANGE_SHORT));
					write_reg(REG_ONE_SHOT, 0);
					write_reg(REG_TICK, 200000);
				end
				1: begin
					write_reg(REG_KNOB, 3);
					write_reg(REG_AMOUNT, CFG_DATA_W'(-32768));
					write_reg(REG_RANGE, CFG_DATA_W'(RANGE_LONG));
					write_reg(REG_ONE_SHOT, 1);
					write_reg(REG_TICK, 500000);
				end
				2: begin
					write_reg(REG_KNOB, 16383);
					write_reg(REG_AMOUNT, 32767);
					write_reg(REG_RANGE, CFG_DATA_W'(RANGE_LONG));
					write_reg(REG_ONE_SHOT, 0);
					write_reg(REG_TICK, 1048575);
				end
				3: begin
					write_reg(REG_KNOB, 1);
					write_reg(REG_AMOUNT, CFG_DATA_W'($urandom));
					write_reg(REG_RANGE, 3);
					write_reg(REG_ONE_SHOT, 1);
					write_reg(REG_TICK, 0);
				end
				4: begin
					write_reg(REG_KNOB, 0);
					write_reg(REG_AMOUNT, CFG_DATA_W'($urandom));
					write_reg(REG_RANGE, CFG_DATA_W'(RANGE_SHORT));
					write_reg(REG_ONE_SHOT, 0);
					write_reg(REG_TICK, 1);
				end
				default: begin
					write_reg(REG_KNOB, CFG_DATA_W'($urandom_range(0, 5)));
					write_reg(REG_AMOUNT, CFG_DATA_W'($urandom));
					write_reg(REG_RANGE, CFG_DATA_W'($urandom_range(0, 3)));
					write_reg(REG_ONE_SHOT, CFG_DATA_W'($urandom_range(0, 1)));
					write_reg(REG_TICK, CFG_DATA_W'($urandom_range(20000, 1048575)));
				end
			endcase
			steady = ph == 3;
			focus = ph % 2 == 0;
			if (ph == 1 || ph == 5)
				squeeze_asked++;
			repeat (PHASE_TICKS) send_tick(random_tick(), 1'b0, '0);
		end

		settle();
		repeat (50) @(posedge clk);
		if (mismatches == 0 && awaited_levels.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
